// ----- src/sis_pkg.sv -----
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and constants for the sorted interval search block.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

    localparam int DATA_W    = 32;
    localparam int IN_IDX_W  = 10;
    localparam int OUT_IDX_W = 10;
    localparam int COUNT_W   = 11;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_LEFT  = 2'd1;
    localparam logic [1:0] OP_RIGHT = 2'd2;

    typedef struct packed {
        logic mem_write;
        logic start;
        logic issue;
        logic step;
        logic out_load;
    } sis_cmd_t;

    typedef struct packed {
        logic span_ok;
        logic hit;
        logic more;
    } sis_stat_t;

endpackage

`default_nettype wire

// ----- src/sorted_interval_search_top.sv -----
// ----------------------------------------------------------------------------
// sorted_interval_search_top
// Binary search bracketing over a table of ascending signed sample positions.
// ----------------------------------------------------------------------------
// A write transaction stores one entry and leaves the block idle. A search
// transaction runs a halving search over the first point_count entries; each
// probe is an issue step, the two-port table read with registered data,
// followed by the compare. When fewer than two points are in use, the search
// makes no probe. One transaction is worked on at a time; a finished result
// waits in the output register while the next transaction is taken.
// point_count may be written only while idle.
`default_nettype none

module sorted_interval_search_top #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [1:0]                          opcode,
    input  wire logic [sis_pkg::IN_IDX_W-1:0]        entry_index,
    input  wire logic signed [sis_pkg::DATA_W-1:0]   entry_value,
    input  wire logic signed [sis_pkg::DATA_W-1:0]   query_value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     found,
    output logic [sis_pkg::OUT_IDX_W-1:0]            interval_index,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sis_pkg::COUNT_W-1:0]         point_count
);
    import sis_pkg::*;

    logic [COUNT_W-1:0] point_count_reg, point_count_next;
    sis_cmd_t           cmd;
    sis_stat_t          stat;

    assign cfg_ready        = 1'b1;
    assign point_count_next = (cfg_valid && cfg_ready) ? point_count : point_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            point_count_reg <= '0;
        else
            point_count_reg <= point_count_next;
    end

    sis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    sis_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .entry_index    (entry_index),
        .entry_value    (entry_value),
        .query_value    (query_value),
        .point_count    (point_count_reg),
        .found          (found),
        .interval_index (interval_index)
    );

endmodule

`default_nettype wire

// ----- src/sis_datapath.sv -----
// ----------------------------------------------------------------------------
// sis_datapath
// Sample table, search bounds, probe compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_datapath #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                clk,
    input  wire sis_pkg::sis_cmd_t                   cmd,
    output sis_pkg::sis_stat_t                       stat,
    input  wire logic [1:0]                          opcode,
    input  wire logic [sis_pkg::IN_IDX_W-1:0]        entry_index,
    input  wire logic signed [sis_pkg::DATA_W-1:0]   entry_value,
    input  wire logic signed [sis_pkg::DATA_W-1:0]   query_value,
    input  wire logic [sis_pkg::COUNT_W-1:0]         point_count,
    output logic                                     found,
    output logic [sis_pkg::OUT_IDX_W-1:0]            interval_index
);
    import sis_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;

    logic signed [VALUE_WIDTH-1:0] sample_table_reg [TABLE_DEPTH];

    logic [IDX_W-1:0]              lo_reg, lo_next;
    logic [IDX_W-1:0]              hi_reg, hi_next;
    logic [IDX_W-1:0]              p_reg;
    logic [IDX_W-1:0]              res_idx_reg, res_idx_next;
    logic                          found_reg, found_next;
    logic                          right_reg;
    logic signed [VALUE_WIDTH-1:0] q_reg;
    logic signed [VALUE_WIDTH-1:0] rd_a_reg, rd_b_reg;
    logic                          found_out_reg;
    logic [OUT_IDX_W-1:0]          index_out_reg;

    logic [CW-1:0]                 used_n;
    logic [IDX_W-1:0]              p_next, p_next1, p1;
    logic signed [63:0]            entry_ext, query_ext;
    logic                          lt_a, gt_b;
    logic [IDX_W-1:0]              lo_step, hi_step;
    logic                          wr_in_range;

    always_comb
    begin
        if (CW'(point_count) > CW'(TABLE_DEPTH))
            used_n = CW'(TABLE_DEPTH);
        else
            used_n = CW'(point_count);
    end

    assign entry_ext   = 64'(entry_value);
    assign query_ext   = 64'(query_value);
    assign wr_in_range = CW'(entry_index) < CW'(TABLE_DEPTH);

    assign p_next  = lo_reg + ((hi_reg - lo_reg - IDX_W'(right_reg)) >> 1);
    assign p_next1 = p_next + IDX_W'(1);
    assign p1      = p_reg + IDX_W'(1);

    always_comb
    begin
        lt_a = right_reg ? (q_reg <= rd_a_reg) : (q_reg < rd_a_reg);
        gt_b = right_reg ? (q_reg > rd_b_reg) : (q_reg >= rd_b_reg);
        lo_step = lo_reg;
        hi_step = hi_reg;
        if (lt_a)
            hi_step = p_reg;
        else if (gt_b)
            lo_step = p1;
    end

    assign stat.span_ok = used_n >= CW'(2);
    assign stat.hit     = !lt_a && !gt_b;
    assign stat.more    = lo_step < hi_step;

    always_comb
    begin
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        found_next   = found_reg;
        res_idx_next = res_idx_reg;
        if (cmd.start)
        begin
            lo_next    = '0;
            hi_next    = IDX_W'(used_n - CW'(1));
            found_next = 1'b0;
        end
        else if (cmd.step)
        begin
            lo_next = lo_step;
            hi_next = hi_step;
            if (!lt_a && !gt_b)
            begin
                found_next   = 1'b1;
                res_idx_next = right_reg ? p1 : p_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write && wr_in_range)
            sample_table_reg[IDX_W'(entry_index)] <= entry_ext[VALUE_WIDTH-1:0];
        if (cmd.issue)
        begin
            rd_a_reg <= sample_table_reg[p_next];
            rd_b_reg <= sample_table_reg[p_next1];
            p_reg    <= p_next;
        end
        if (cmd.start)
        begin
            q_reg     <= query_ext[VALUE_WIDTH-1:0];
            right_reg <= (opcode == OP_RIGHT);
        end
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        found_reg   <= found_next;
        res_idx_reg <= res_idx_next;
        if (cmd.out_load)
        begin
            found_out_reg <= found_reg;
            index_out_reg <= found_reg ? OUT_IDX_W'(res_idx_reg) : '0;
        end
    end

    assign found          = found_out_reg;
    assign interval_index = index_out_reg;

endmodule

`default_nettype wire

// ----- src/sis_ctrl.sv -----
// ----------------------------------------------------------------------------
// sis_ctrl
// Sequencer: accepts transactions, steps the probe loop, hands off results.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        opcode,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output sis_pkg::sis_cmd_t      cmd,
    input  wire sis_pkg::sis_stat_t stat
);
    import sis_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_ISSUE   = 4'b0010,
        S_COMPARE = 4'b0100,
        S_FINISH  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode) inside
                        OP_WRITE:
                            cmd.mem_write = 1'b1;
                        OP_LEFT, OP_RIGHT:
                        begin
                            cmd.start  = 1'b1;
                            state_next = stat.span_ok ? S_ISSUE : S_FINISH;
                        end
                        default: ;
                    endcase
                end
            end
            S_ISSUE:
            begin
                cmd.issue  = 1'b1;
                state_next = S_COMPARE;
            end
            S_COMPARE:
            begin
                cmd.step = 1'b1;
                if (!stat.hit && stat.more)
                    state_next = S_ISSUE;
                else
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/sis_checker.sv -----
// ----------------------------------------------------------------------------
// sis_checker
// Port-level checks on transaction sequencing and result encoding.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic                                in_stall,
    input  wire logic [1:0]                          opcode,
    input  wire logic                                out_valid,
    input  wire logic                                out_stall,
    input  wire logic                                found,
    input  wire logic [sis_pkg::OUT_IDX_W-1:0]       interval_index
);
    import sis_pkg::*;

    // a search keeps the input side busy for at least the following cycle
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (opcode == OP_LEFT || opcode == OP_RIGHT)
        |=> in_stall)
        else $error("search transaction did not hold off the input");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> interval_index == '0)
        else $error("miss reported with non-zero index");

    // results appear only out of a busy search
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a search in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall
        |=> out_valid && $stable(found) && $stable(interval_index))
        else $error("stalled result changed");

endmodule

bind sorted_interval_search_top sis_checker u_sis_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .found          (found),
    .interval_index (interval_index)
);

`default_nettype wire
